// File: hw/rtl/mec_pkg.sv
package mec_pkg;

  // field widths
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned GAIN_W  = 9;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // digit-by-digit square root takes one result bit per step
  localparam int unsigned SQRT_STEPS = MAG_W;

  // unity weight of the smoothing filter
  localparam logic [GAIN_W-1:0] GAIN_ONE = 9'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RISE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd4;

  // configuration reset values
  localparam logic [CFG_W-1:0]  RISE_RESET     = 16'd20480;
  localparam logic [CFG_W-1:0]  FALL_RESET     = 16'd18022;
  localparam logic [CFG_W-1:0]  DEBOUNCE_RESET = 16'd300;
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 9'd77;
  localparam logic [CFG_W-1:0]  START_RESET    = 16'd16384;

  typedef struct packed {
    logic [CFG_W-1:0]  rise_level;
    logic [CFG_W-1:0]  fall_level;
    logic [CFG_W-1:0]  debounce_ms;
    logic [GAIN_W-1:0] ema_gain;
    logic [CFG_W-1:0]  start_level;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic [SUM_W-1:0]  sum_sq;
    logic [TIME_W-1:0] time_ms;
    logic              clear;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: hw/rtl/mec_front.sv
module mec_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [15:0]        accel_x_i,
  input  logic signed [15:0]        accel_y_i,
  input  logic signed [15:0]        accel_z_i,
  input  logic [31:0]               time_ms_i,
  input  logic                      clear_i,
  input  mec_pkg::fifo_stat_t       stat_i,
  output logic                      push_o,
  output mec_pkg::q_item_t          item_o
);
  import mec_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ   = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam logic [1:0] LAST_AXIS = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [1:0]        axis_q, axis_d;
  logic [AXIS_W-1:0] x_q, y_q, z_q;
  logic [SUM_W-1:0]  sum_q;
  logic [TIME_W-1:0] time_q;
  logic              clr_q;
  logic              accept;

  logic [AXIS_W-1:0] sel;
  logic [AXIS_W:0]   sel_neg;
  logic [AXIS_W-1:0] abs_v;
  logic [SUM_W-1:0]  sq;

  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !stat_i.full;

  // one axis squared per cycle through a single multiplier
  always_comb begin
    case (axis_q)
      2'd0:    sel = x_q;
      2'd1:    sel = y_q;
      default: sel = z_q;
    endcase
  end

  assign sel_neg = -{sel[AXIS_W-1], sel};
  assign abs_v   = sel[AXIS_W-1] ? sel_neg[AXIS_W-1:0] : sel;
  assign sq      = {16'd0, abs_v} * {16'd0, abs_v};

  // sequencing
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = clear_i ? F_PUSH : F_SQ;
          axis_d  = 2'd0;
        end
      end
      F_SQ: begin
        axis_d = axis_q + 2'd1;
        if (axis_q == LAST_AXIS) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!stat_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // sample capture and sum of squares
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= accel_x_i;
      y_q    <= accel_y_i;
      z_q    <= accel_z_i;
      time_q <= time_ms_i;
      clr_q  <= clear_i;
      sum_q  <= '0;
    end else if (state_q == F_SQ) begin
      sum_q <= sum_q + sq;
    end
  end

  assign item_o.sum_sq  = sum_q;
  assign item_o.time_ms = time_q;
  assign item_o.clear   = clr_q;

endmodule

// File: hw/rtl/mec_fifo.sv
module mec_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mec_pkg::q_item_t    item_i,
  input  logic                pop_i,
  output mec_pkg::q_item_t    item_o,
  output mec_pkg::fifo_stat_t stat_o
);
  import mec_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_item_t       mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/mec_back.sv
module mec_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mec_pkg::cfg_t       cfg_i,
  input  mec_pkg::q_item_t    item_i,
  input  mec_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                event_res_o,
  output logic [31:0]         count_o,
  output logic [15:0]         level_o
);
  import mec_pkg::*;

  localparam int unsigned SW = LEVEL_W + FRAC_BITS;
  localparam int unsigned AW = SW + GAIN_W;
  localparam int unsigned RW = MAG_W + 1;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQRT = 3'd1;
  localparam logic [2:0] B_MUL1 = 3'd2;
  localparam logic [2:0] B_MUL2 = 3'd3;
  localparam logic [2:0] B_DET  = 3'd4;

  localparam logic [3:0] SQRT_LAST = 4'(SQRT_STEPS - 1);

  logic [2:0]         state_q;
  logic [3:0]         cnt_q;
  logic [SW-1:0]      smoothed_q;
  logic               armed_q;
  logic [TIME_W-1:0]  last_q;
  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;

  logic [SUM_W-1:0]   n_q;
  logic [RW-1:0]      rem_q;
  logic [MAG_W-1:0]   root_q;
  logic [TIME_W-1:0]  time_q;
  logic               clr_q;
  logic [AW-1:0]      prod_q;
  logic [SW-1:0]      news_q;
  logic               ev_q;
  logic [COUNT_W-1:0] cnt_out_q;
  logic [LEVEL_W-1:0] level_q;

  logic               out_free;
  logic               commit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (state_q == B_DET) && out_free;
  assign pop_o    = (state_q == B_IDLE) && !stat_i.empty;
  assign busy_o   = (state_q != B_IDLE);

  // square root step: bring down two radicand bits, try to subtract
  logic [RW+1:0] rem_next;
  logic [RW+1:0] trial;
  logic          take;
  logic [RW+1:0] rem_sub;

  assign rem_next = {rem_q, n_q[SUM_W-1 -: 2]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign take     = (rem_next >= trial);
  assign rem_sub  = take ? (rem_next - trial) : rem_next;

  // filter arithmetic
  logic [GAIN_W-1:0] gain_sat;
  logic [GAIN_W-1:0] gain_inv;
  logic [SW-1:0]     mag_fx;
  logic [AW-1:0]     prod;
  logic [AW-1:0]     acc;

  assign gain_sat = (cfg_i.ema_gain > GAIN_ONE) ? GAIN_ONE : cfg_i.ema_gain;
  assign gain_inv = GAIN_ONE - gain_sat;
  assign mag_fx   = {root_q, {FRAC_BITS{1'b0}}};
  assign prod     = gain_sat * mag_fx;
  assign acc      = prod_q + gain_inv * smoothed_q;

  // hysteresis and debounce
  logic [SW-1:0]     rise_fx;
  logic [SW-1:0]     fall_fx;
  logic [SW-1:0]     start_fx;
  logic [TIME_W-1:0] dt;
  logic              arm_set;
  logic              fire;
  logic              deb_ok;
  logic              ev;

  assign rise_fx  = {cfg_i.rise_level, {FRAC_BITS{1'b0}}};
  assign fall_fx  = {cfg_i.fall_level, {FRAC_BITS{1'b0}}};
  assign start_fx = {cfg_i.start_level, {FRAC_BITS{1'b0}}};
  assign dt       = time_q - last_q;
  assign arm_set  = (news_q > rise_fx) && !armed_q;
  assign fire     = !arm_set && (news_q < fall_fx) && armed_q;
  assign deb_ok   = (dt >= {16'd0, cfg_i.debounce_ms});
  assign ev       = !clr_q && fire && deb_ok;

  // sequencer and detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      smoothed_q  <= {START_RESET, {FRAC_BITS{1'b0}}};
      armed_q     <= 1'b0;
      last_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!stat_i.empty) begin
            state_q <= item_i.clear ? B_DET : B_SQRT;
            cnt_q   <= '0;
          end
        end
        B_SQRT: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == SQRT_LAST) begin
            state_q <= B_MUL1;
          end
        end
        B_MUL1: state_q <= B_MUL2;
        B_MUL2: state_q <= B_DET;
        B_DET: begin
          if (out_free) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase

      if (commit) begin
        if (clr_q) begin
          smoothed_q <= start_fx;
          armed_q    <= 1'b0;
          last_q     <= '0;
          count_q    <= '0;
        end else begin
          smoothed_q <= news_q;
          if (arm_set) begin
            armed_q <= 1'b1;
          end else if (fire) begin
            armed_q <= 1'b0;
            if (deb_ok) begin
              count_q <= count_q + 1'b1;
              last_q  <= time_q;
            end
          end
        end
      end

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      n_q    <= item_i.sum_sq;
      time_q <= item_i.time_ms;
      clr_q  <= item_i.clear;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == B_SQRT) begin
      n_q    <= {n_q[SUM_W-3:0], 2'b00};
      rem_q  <= rem_sub[RW-1:0];
      root_q <= {root_q[MAG_W-2:0], take};
    end
    if (state_q == B_MUL1) begin
      prod_q <= prod;
    end
    if (state_q == B_MUL2) begin
      news_q <= acc[SW+7:8];
    end
    if (commit) begin
      ev_q      <= ev;
      cnt_out_q <= clr_q ? '0 : (ev ? count_q + 1'b1 : count_q);
      level_q   <= clr_q ? cfg_i.start_level : news_q[SW-1:FRAC_BITS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign count_o     = cnt_out_q;
  assign level_o     = level_q;

endmodule

// File: hw/rtl/motion_event_counter_unit.sv
// Movement counter for one accelerometer channel.
// Input channel: in_valid_i / in_stall_o carries one sample (three signed axes,
// a millisecond timestamp, a clear flag); a transfer happens when valid is high
// and stall is low. Output channel: out_valid_o / out_stall_i carries one
// result per sample: event flag, running count and integer smoothed level.
// The front stage squares the three axes on one multiplier (one axis a cycle)
// and takes no new sample until it has pushed the last one into the queue; a
// clear sample skips the squares. A two-entry queue separates it from the back
// stage, which pops an item, runs the bit-per-step square root, then the filter
// steps B_MUL1 and B_MUL2 (one multiplier each) and then the detector; it pops
// no new item before the detector has handed its result on. A clear sample
// goes from the pop straight to the detector step.
// The result sits in an output register; while the receiver stalls the back
// stage keeps working and waits only at the detector step, and the front keeps
// filling the queue. Reset loads default thresholds, empties the queue, clears
// count, arm flag and last event time, and loads the start level.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and are expected only while no sample is in flight.
module motion_event_counter_unit #(
  parameter int unsigned FRAC_BITS   = 8,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic [31:0]        time_ms_i,
  input  logic               clear_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               event_res_o,
  output logic [31:0]        count_o,
  output logic [15:0]        level_o
);
  import mec_pkg::*;

  cfg_t       cfg_q, cfg_d;
  q_item_t    front_item, back_item;
  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;
  logic       back_busy;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RISE:     cfg_d.rise_level  = cfg_data_i;
        CFG_FALL:     cfg_d.fall_level  = cfg_data_i;
        CFG_DEBOUNCE: cfg_d.debounce_ms = cfg_data_i;
        CFG_GAIN:     cfg_d.ema_gain    = cfg_data_i[GAIN_W-1:0];
        CFG_START:    cfg_d.start_level = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_level  <= RISE_RESET;
      cfg_q.fall_level  <= FALL_RESET;
      cfg_q.debounce_ms <= DEBOUNCE_RESET;
      cfg_q.ema_gain    <= GAIN_RESET;
      cfg_q.start_level <= START_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sample capture and sum of squares
  mec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .accel_x_i  (accel_x_i),
    .accel_y_i  (accel_y_i),
    .accel_z_i  (accel_z_i),
    .time_ms_i  (time_ms_i),
    .clear_i    (clear_i),
    .stat_i     (fifo_stat),
    .push_o     (push),
    .item_o     (front_item)
  );

  // queue between front and back
  mec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (back_item),
    .stat_o (fifo_stat)
  );

  // square root, filter and detector
  mec_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (back_item),
    .stat_i      (fifo_stat),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (event_res_o),
    .count_o     (count_o),
    .level_o     (level_o)
  );

  // front is busy right after it takes a sample
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("front took a second sample without a busy cycle");

  // queue cannot report full and empty together
  a_fifo_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue status inconsistent");

  // a new result comes only from a working back stage
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_busy))
    else $error("result appeared while back stage was idle");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

endmodule

// File: verif/motion_event_counter_unit_tb.sv
module motion_event_counter_unit_tb;
  import mec_pkg::*;

  localparam int unsigned FX_BITS = 8;
  localparam int unsigned FX_W    = LEVEL_W + FX_BITS;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic [TIME_W-1:0]        stamp;
    logic                     clr;
  } motion_sample_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] total;
    logic [LEVEL_W-1:0] level;
  } count_report_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    motion_sample_t       sample;
    logic                 typed;
    count_report_t        outcome;
  } script_row_t;

  // block ports
  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [2:0]         cfg_idx_i  = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] accel_x_i  = '0;
  logic signed [15:0] accel_y_i  = '0;
  logic signed [15:0] accel_z_i  = '0;
  logic [31:0]        time_ms_i  = '0;
  logic               clear_i    = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               event_res_o;
  logic [31:0]        count_o;
  logic [15:0]        level_o;

  // register copies for the counter model
  logic [CFG_W-1:0]  rise_cfg     = RISE_RESET;
  logic [CFG_W-1:0]  fall_cfg     = FALL_RESET;
  logic [CFG_W-1:0]  debounce_cfg = DEBOUNCE_RESET;
  logic [GAIN_W-1:0] gain_cfg     = GAIN_RESET;
  logic [CFG_W-1:0]  start_cfg    = START_RESET;

  // counter model state
  logic [FX_W-1:0]    smooth_fx;
  logic               armed_now;
  logic [TIME_W-1:0]  last_hit_ms;
  logic [COUNT_W-1:0] hit_count;

  count_report_t expected_reports[$];
  count_report_t due;
  script_row_t   script[$];
  int unsigned   mismatches = 0;
  bit            steady = 1'b0;

  // motion pattern state
  bit            swing_high = 1'b0;
  int unsigned   swing_left = 0;
  logic [31:0]   clock_ms = '0;

  motion_event_counter_unit #(
    .FRAC_BITS(FX_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .accel_x_i  (accel_x_i),
    .accel_y_i  (accel_y_i),
    .accel_z_i  (accel_z_i),
    .time_ms_i  (time_ms_i),
    .clear_i    (clear_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .event_res_o(event_res_o),
    .count_o    (count_o),
    .level_o    (level_o)
  );

  always #2 clk_i = ~clk_i;

  // floor square root, one result bit at a time from the top
  function automatic logic [MAG_W-1:0] root_floor(input logic [SUM_W-1:0] n);
    logic [MAG_W-1:0] r;
    logic [MAG_W-1:0] trial;
    int b;
    r = '0;
    for (b = MAG_W - 1; b >= 0; b--) begin
      trial = r | (MAG_W'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(n)) r = trial;
    end
    return r;
  endfunction

  function automatic void restore_counter();
    smooth_fx   = FX_W'(start_cfg) << FX_BITS;
    armed_now   = 1'b0;
    last_hit_ms = '0;
    hit_count   = '0;
  endfunction

  // filter, hysteresis and debounce for one sample, or a model reset on a clear
  function automatic count_report_t advance_counter(input motion_sample_t s);
    int                xa, ya, za;
    longint unsigned   sq, acc;
    logic [MAG_W-1:0]  mag;
    logic [GAIN_W-1:0] g;
    logic [TIME_W-1:0] since;
    count_report_t     r;
    r.hit = 1'b0;
    if (s.clr) begin
      restore_counter();
    end else begin
      xa = $signed(s.x);
      ya = $signed(s.y);
      za = $signed(s.z);
      if (xa < 0) xa = -xa;
      if (ya < 0) ya = -ya;
      if (za < 0) za = -za;
      sq  = 64'(xa * xa) + 64'(ya * ya) + 64'(za * za);
      mag = root_floor(sq[SUM_W-1:0]);
      // weights above unity saturate
      g   = (gain_cfg > GAIN_ONE) ? GAIN_ONE : gain_cfg;
      acc = 64'(g) * (64'(mag) << FX_BITS) + 64'(GAIN_ONE - g) * 64'(smooth_fx);
      smooth_fx = acc[8 +: FX_W];
      if (64'(smooth_fx) > (64'(rise_cfg) << FX_BITS) && !armed_now) begin
        armed_now = 1'b1;
      end else if (64'(smooth_fx) < (64'(fall_cfg) << FX_BITS) && armed_now) begin
        armed_now = 1'b0;
        since = s.stamp - last_hit_ms;
        if (since >= TIME_W'(debounce_cfg)) begin
          hit_count   = hit_count + 1'b1;
          last_hit_ms = s.stamp;
          r.hit       = 1'b1;
        end
      end
    end
    r.total = hit_count;
    r.level = smooth_fx[FX_BITS +: LEVEL_W];
    return r;
  endfunction

  // mostly swings above rise and below fall, some noise and clears
  function automatic motion_sample_t next_motion();
    motion_sample_t s;
    int unsigned    pick, target;
    int             xi, yi, zi;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(10, 350);
    s.stamp = clock_ms;
    s.clr   = 1'b0;
    if (pick < 20) begin
      s.x = AXIS_W'($urandom());
      s.y = AXIS_W'($urandom());
      s.z = AXIS_W'($urandom());
      s.clr = (pick < 3);
    end else begin
      if (swing_left == 0) begin
        swing_high = !swing_high;
        swing_left = $urandom_range(2, 8);
      end
      swing_left--;
      if (swing_high) begin
        target = rise_cfg + $urandom_range(500, 12000);
        if (target > 56000) target = 56000;
      end else begin
        target = (fall_cfg > 600) ? $urandom_range(0, fall_cfg - 500) : 0;
      end
      zi = (target > 32767) ? 32767 : target;
      yi = target - zi;
      xi = int'($urandom_range(0, 400)) - 200;
      if ($urandom_range(1)) yi = -yi;
      if ($urandom_range(1)) zi = -zi;
      s.x = AXIS_W'(xi);
      s.y = AXIS_W'(yi);
      s.z = AXIS_W'(zi);
    end
    return s;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
    script_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    script.push_back(row);
  endfunction

  function automatic void add_sample(input int x, input int y, input int z,
                                     input logic [31:0] t, input bit c,
                                     input bit typed, input bit hit,
                                     input logic [31:0] total, input int level);
    script_row_t row;
    row               = '0;
    row.kind          = ROW_SAMPLE;
    row.sample.x      = AXIS_W'(x);
    row.sample.y      = AXIS_W'(y);
    row.sample.z      = AXIS_W'(z);
    row.sample.stamp  = t;
    row.sample.clr    = c;
    row.typed         = typed;
    row.outcome.hit   = hit;
    row.outcome.total = total;
    row.outcome.level = LEVEL_W'(level);
    script.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // stop sending and wait for every pending result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_RISE:     rise_cfg     = data;
      CFG_FALL:     fall_cfg     = data;
      CFG_DEBOUNCE: debounce_cfg = data;
      CFG_GAIN:     gain_cfg     = data[GAIN_W-1:0];
      CFG_START:    start_cfg    = data;
      default: ;
    endcase
  endtask

  task automatic program_phase(input logic [CFG_W-1:0] rise, input logic [CFG_W-1:0] fall,
                               input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] gain,
                               input logic [CFG_W-1:0] start);
    write_reg(CFG_RISE, rise);
    write_reg(CFG_FALL, fall);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_START, start);
  endtask

  // one sample transfer, with random gaps ahead of it
  task automatic send_sample(input motion_sample_t s, input bit typed,
                             input count_report_t fixed);
    count_report_t predicted;
    cfg_we_i <= 1'b0;
    while (!steady && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= s.x;
    accel_y_i  <= s.y;
    accel_z_i  <= s.z;
    time_ms_i  <= s.stamp;
    clear_i    <= s.clr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_counter(s);
    expected_reports.push_back(typed ? fixed : predicted);
  endtask

  // result side: random stall, compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch("result transfer with nothing pending");
      end else begin
        due = expected_reports.pop_front();
        if (event_res_o !== due.hit)
          flag_mismatch($sformatf("event_res %0b, want %0b", event_res_o, due.hit));
        if (count_o !== due.total)
          flag_mismatch($sformatf("count %0d, want %0d", count_o, due.total));
        if (level_o !== due.level)
          flag_mismatch($sformatf("level %0d, want %0d", level_o, due.level));
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < 13);
  end

  initial begin : stimulus
    int unsigned      p, n, quota;
    logic [CFG_W-1:0] rise;
    count_report_t    blank;
    blank = '0;
    restore_counter();

    // directed rows, reset settings first
    add_sample(1234, -5, 77, 999, 1, 1, 0, 0, 16384);
    add_sample(100, -200, 16384, 5, 0, 0, 0, 0, 0);
    // gain above unity saturates, level follows the magnitude
    add_write(CFG_GAIN, 16'hFFFF);
    add_sample(0, 0, 0, 10, 0, 1, 0, 0, 0);
    add_sample(-32768, 0, 0, 20, 0, 1, 0, 0, 32768);
    // armed and still above rise
    add_sample(0, 0, 32767, 30, 0, 1, 0, 0, 32767);
    // first fall comes before the debounce time
    add_sample(0, 0, 0, 100, 0, 1, 0, 0, 0);
    add_sample(32767, -32768, 32767, 400, 0, 0, 0, 0, 0);
    add_sample(0, 0, 0, 400, 0, 1, 1, 1, 0);
    add_sample(-32768, -32768, -32768, 500, 0, 1, 0, 1, 56755);
    // debounce not met, disarm only
    add_sample(0, 0, 0, 650, 0, 1, 0, 1, 0);
    // fall above rise, time wraps
    add_write(CFG_RISE, 16'h0000);
    add_write(CFG_FALL, 16'hFFFF);
    add_sample(3, 4, 0, 32'hFFFF_FFFF, 0, 1, 0, 1, 5);
    add_sample(3, -4, 0, 0, 0, 1, 1, 2, 5);
    add_sample(0, 0, 0, 0, 0, 1, 0, 2, 0);
    add_write(CFG_DEBOUNCE, 16'h0000);
    add_sample(0, 0, 1, 0, 0, 1, 0, 2, 1);
    add_sample(0, 0, -1, 0, 0, 1, 1, 3, 1);
    add_write(CFG_DEBOUNCE, 16'hFFFF);
    add_sample(0, 1, 0, 1, 0, 1, 0, 3, 1);
    add_sample(0, 1, 0, 65534, 0, 1, 0, 3, 1);
    add_sample(0, -1, 0, 65535, 0, 1, 0, 3, 1);
    add_sample(1, 0, 0, 65535, 0, 1, 1, 4, 1);
    // zero gain holds the level
    add_write(CFG_GAIN, 16'h0000);
    add_sample(-32768, -32768, -32768, 70000, 0, 1, 0, 4, 1);
    add_write(CFG_START, 16'hFFFF);
    add_sample(0, 0, 0, 0, 1, 1, 0, 0, 65535);
    add_write(CFG_START, 16'h0000);
    add_sample(-1, -1, -1, 32'hFFFF_FFFF, 1, 1, 0, 0, 0);
    add_write(CFG_GAIN, 16'd128);
    add_sample(12345, -23456, 345, 1000, 0, 0, 0, 0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) write_reg(script[i].idx, script[i].data);
      else send_sample(script[i].sample, script[i].typed, script[i].outcome);
    end

    // random phases, each with its own settings
    for (p = 0; p < 6; p++) begin
      case (p)
        0: program_phase(RISE_RESET, FALL_RESET, DEBOUNCE_RESET, CFG_W'(GAIN_RESET),
                         START_RESET);
        1: program_phase(16'hFFFF, 16'h0000, 16'hFFFF, CFG_W'(GAIN_ONE), 16'hFFFF);
        2: program_phase(16'h0000, 16'hFFFF, 16'h0000, 16'h01FF, 16'h0000);
        default: begin
          rise = CFG_W'($urandom_range(2000, 40000));
          program_phase(rise,
                        ($urandom_range(99) < 80)
                          ? CFG_W'(rise - $urandom_range(0, rise / 2))
                          : CFG_W'($urandom()),
                        ($urandom_range(99) < 80) ? CFG_W'($urandom_range(0, 900))
                                                  : CFG_W'($urandom()),
                        ($urandom_range(99) < 85) ? CFG_W'($urandom_range(40, 256))
                                                  : CFG_W'($urandom_range(0, 511)),
                        CFG_W'($urandom()));
        end
      endcase
      // one whole phase runs with no idling on either side
      steady = (p == 3);
      quota  = (p == 1) ? 50 : 110;
      for (n = 0; n < quota; n++) send_sample(next_motion(), 1'b0, blank);
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("motion_event_counter_unit_tb passed");
    end else begin
      $display("motion_event_counter_unit_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("motion_event_counter_unit_tb failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mec_pkg.sv
hw/rtl/mec_front.sv
hw/rtl/mec_fifo.sv
hw/rtl/mec_back.sv
hw/rtl/motion_event_counter_unit.sv
verif/motion_event_counter_unit_tb.sv
